FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the map checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bkvm_pkg.sv
// ---------------------------------------------------------------------------
// bkvm_pkg
// Operation codes, port widths and the request/response words of the map.
// ---------------------------------------------------------------------------
package bkvm_pkg;

  // fixed widths of the channel fields
  localparam int OP_W      = 3;
  localparam int KEY_IO_W  = 32;
  localparam int VAL_IO_W  = 64;
  localparam int POS_W     = 8;
  localparam int CNT_IO_W  = 9;
  localparam int CAP_W     = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT           = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE           = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT_OR_UPDATE = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE            = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAINS         = 3'd4;
  localparam logic [OP_W-1:0] OP_GET_BY_KEY       = 3'd5;
  localparam logic [OP_W-1:0] OP_GET_BY_INDEX     = 3'd6;
  localparam logic [OP_W-1:0] OP_NONE             = 3'd7;

  // request word as taken from the input ports
  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_IO_W-1:0] key;
    logic [VAL_IO_W-1:0] value;
    logic [POS_W-1:0]    pos;
  } req_t;

  // response word driven on the result ports
  typedef struct packed {
    logic                ok;
    logic [KEY_IO_W-1:0] key;
    logic [VAL_IO_W-1:0] value;
    logic [CNT_IO_W-1:0] count;
    logic                empty;
  } resp_t;

endpackage

FILE: hw/rtl/bkvm_store.sv
// ---------------------------------------------------------------------------
// bkvm_store
// Key and value memories: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module bkvm_store #(
  parameter int DEPTH       = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64,
  parameter int AW          = 8
) (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output logic [KEY_WIDTH-1:0]   rd_key,
  output logic [VALUE_WIDTH-1:0] rd_value,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [KEY_WIDTH-1:0]   wr_key,
  input  logic [VALUE_WIDTH-1:0] wr_value
);

  logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
  logic [VALUE_WIDTH-1:0] val_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_value;
    end
  end

  // read port, data in the cycle after the address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_value <= val_mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/bkvm_ctrl.sv
// ---------------------------------------------------------------------------
// bkvm_ctrl
// Sequencer: linear key scan over the store, write-back and result word.
// ---------------------------------------------------------------------------
module bkvm_ctrl #(
  parameter int DEPTH       = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64,
  parameter int AW          = 8,
  parameter int CW          = 9
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  bkvm_pkg::req_t            req,
  output logic                      busy,
  input  logic                      cfg_wr_en,
  input  logic [bkvm_pkg::CAP_W-1:0] cfg_wr_data,
  output logic                      rd_en,
  output logic [AW-1:0]             rd_addr,
  input  logic [KEY_WIDTH-1:0]      rd_key,
  input  logic [VALUE_WIDTH-1:0]    rd_value,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [KEY_WIDTH-1:0]      wr_key,
  output logic [VALUE_WIDTH-1:0]    wr_value,
  output logic                      out_valid,
  output bkvm_pkg::resp_t           out_resp
);

  import bkvm_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_ERASE_RD = 3'd2;
  localparam logic [2:0] S_ERASE_WR = 3'd3;
  localparam logic [2:0] S_INDEX_WR = 3'd4;

  logic [2:0]             state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [CAP_W-1:0]       cap_r, cap_nxt;
  logic [CW-1:0]          iss_r, iss_nxt;
  logic                   chk_v_r, chk_v_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OP_W-1:0]        op_r, op_nxt;
  logic [KEY_WIDTH-1:0]   key_r, key_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [AW-1:0]          chk_idx_r, chk_idx_nxt;
  logic [AW-1:0]          slot_r, slot_nxt;
  resp_t                  resp_r, resp_nxt;

  logic          room;
  logic          hit;
  logic [CW-1:0] last_idx;

  // a new key fits when the count is below both the limit and the depth
  assign room     = (32'(count_r) < 32'(cap_r)) && (32'(count_r) < DEPTH);
  assign hit      = chk_v_r && (rd_key == key_r);
  assign last_idx = count_r - 1'b1;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_resp  = resp_r;

  // next-state and memory port logic
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    iss_nxt       = iss_r;
    chk_v_nxt     = chk_v_r;
    chk_idx_nxt   = chk_idx_r;
    slot_nxt      = slot_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    resp_nxt      = resp_r;
    rd_en         = 1'b0;
    rd_addr       = iss_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = slot_r;
    wr_key        = key_r;
    wr_value      = value_r;

    if (cfg_wr_en) begin
      cap_nxt = cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt    = req.op;
          key_nxt   = KEY_WIDTH'(req.key);
          value_nxt = VALUE_WIDTH'(req.value);
          case (req.op)
            OP_INSERT, OP_UPDATE, OP_INSERT_OR_UPDATE,
            OP_ERASE, OP_CONTAINS, OP_GET_BY_KEY: begin
              iss_nxt   = '0;
              chk_v_nxt = 1'b0;
              state_nxt = S_SCAN;
            end
            OP_GET_BY_INDEX: begin
              if (32'(req.pos) < 32'(count_r)) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(req.pos);
                state_nxt = S_INDEX_WR;
              end else begin
                out_valid_nxt  = 1'b1;
                resp_nxt.ok    = 1'b0;
                resp_nxt.key   = '0;
                resp_nxt.value = '0;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              resp_nxt.ok    = 1'b0;
              resp_nxt.key   = '0;
              resp_nxt.value = '0;
            end
          endcase
        end
      end

      // one read issued and one compare done per cycle
      S_SCAN: begin
        resp_nxt.key   = '0;
        resp_nxt.value = '0;
        if (hit) begin
          case (op_r)
            OP_UPDATE, OP_INSERT_OR_UPDATE: begin
              wr_en         = 1'b1;
              wr_addr       = chk_idx_r;
              out_valid_nxt = 1'b1;
              resp_nxt.ok   = 1'b1;
              state_nxt     = S_IDLE;
            end
            OP_ERASE: begin
              slot_nxt  = chk_idx_r;
              state_nxt = S_ERASE_RD;
            end
            OP_CONTAINS: begin
              out_valid_nxt = 1'b1;
              resp_nxt.ok   = 1'b1;
              state_nxt     = S_IDLE;
            end
            OP_GET_BY_KEY: begin
              out_valid_nxt  = 1'b1;
              resp_nxt.ok    = 1'b1;
              resp_nxt.value = VAL_IO_W'(rd_value);
              state_nxt      = S_IDLE;
            end
            default: begin
              out_valid_nxt = 1'b1;
              resp_nxt.ok   = 1'b0;
              state_nxt     = S_IDLE;
            end
          endcase
        end else if (iss_r >= count_r) begin
          // key absent: only inserts act
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if ((op_r == OP_INSERT || op_r == OP_INSERT_OR_UPDATE) && room) begin
            wr_en       = 1'b1;
            wr_addr     = count_r[AW-1:0];
            count_nxt   = count_r + 1'b1;
            resp_nxt.ok = 1'b1;
          end else begin
            resp_nxt.ok = 1'b0;
          end
        end else begin
          rd_en       = 1'b1;
          chk_v_nxt   = 1'b1;
          chk_idx_nxt = iss_r[AW-1:0];
          iss_nxt     = iss_r + 1'b1;
        end
      end

      // fetch the last pair to fill the freed slot
      S_ERASE_RD: begin
        rd_en     = 1'b1;
        rd_addr   = last_idx[AW-1:0];
        state_nxt = S_ERASE_WR;
      end

      S_ERASE_WR: begin
        wr_en          = 1'b1;
        wr_addr        = slot_r;
        wr_key         = rd_key;
        wr_value       = rd_value;
        count_nxt      = last_idx;
        out_valid_nxt  = 1'b1;
        resp_nxt.ok    = 1'b1;
        resp_nxt.key   = '0;
        resp_nxt.value = '0;
        state_nxt      = S_IDLE;
      end

      S_INDEX_WR: begin
        out_valid_nxt  = 1'b1;
        resp_nxt.ok    = 1'b1;
        resp_nxt.key   = KEY_IO_W'(rd_key);
        resp_nxt.value = VAL_IO_W'(rd_value);
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // count and empty flag reflect the map after the request
    if (out_valid_nxt) begin
      resp_nxt.count = CNT_IO_W'(count_nxt);
      resp_nxt.empty = (count_nxt == '0);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cap_r       <= CAP_RESET;
      iss_r       <= '0;
      chk_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cap_r       <= cap_nxt;
      iss_r       <= iss_nxt;
      chk_v_r     <= chk_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    value_r   <= value_nxt;
    chk_idx_r <= chk_idx_nxt;
    slot_r    <= slot_nxt;
    resp_r    <= resp_nxt;
  end

endmodule

FILE: hw/rtl/bounded_key_value_map.sv
// ---------------------------------------------------------------------------
// bounded_key_value_map
// Fixed-capacity key/value map kept unordered in memory, searched linearly.
// ---------------------------------------------------------------------------
// Usage
//   Request word: present in_operation, in_lookup_key, in_new_value and
//   in_position with start high; it is taken at the edge where busy is low.
//   Result word: out_valid is high for exactly one cycle with out_ok,
//   out_found_key, out_found_value, out_entry_count and out_is_empty.
//   The receiver cannot stall, so every result is taken in that cycle.
//   Sequence, from the accepting edge to the result strobe:
//     key requests (insert, update, erase, contains, get_by_key): a scan
//     that reads one stored key per cycle through the single read port
//     until a match or all held pairs are read; erase then fetches the last
//     pair and writes it into the freed slot.
//     get_by_index: reads the slot when in range, else fails; unused code: fails.
//   A new request may be taken in the cycle its predecessor's result
//   is on the ports.
//   Configuration: cfg_wr_en writes cfg_wr_data to the capacity limit.
//   Reset (rst_n low, synchronous) empties the map and sets the capacity
//   limit to 256; memory contents are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module bounded_key_value_map #(
  parameter int DEPTH       = 256,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [bkvm_pkg::OP_W-1:0]     in_operation,
  input  logic [bkvm_pkg::KEY_IO_W-1:0] in_lookup_key,
  input  logic [bkvm_pkg::VAL_IO_W-1:0] in_new_value,
  input  logic [bkvm_pkg::POS_W-1:0]    in_position,
  input  logic                          cfg_wr_en,
  input  logic [bkvm_pkg::CAP_W-1:0]    cfg_wr_data,
  output logic                          out_valid,
  output logic                          out_ok,
  output logic [bkvm_pkg::KEY_IO_W-1:0] out_found_key,
  output logic [bkvm_pkg::VAL_IO_W-1:0] out_found_value,
  output logic [bkvm_pkg::CNT_IO_W-1:0] out_entry_count,
  output logic                          out_is_empty
);

  import bkvm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t                   req;
  resp_t                  resp;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_value;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [KEY_WIDTH-1:0]   wr_key;
  logic [VALUE_WIDTH-1:0] wr_value;

  // gather the request word
  assign req.op    = in_operation;
  assign req.key   = in_lookup_key;
  assign req.value = in_new_value;
  assign req.pos   = in_position;

  bkvm_ctrl #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .req         (req),
    .busy        (busy),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_key      (rd_key),
    .rd_value    (rd_value),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_key      (wr_key),
    .wr_value    (wr_value),
    .out_valid   (out_valid),
    .out_resp    (resp)
  );

  bkvm_store #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW)
  ) u_store (
    .clk      (clk),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_key   (rd_key),
    .rd_value (rd_value),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_key   (wr_key),
    .wr_value (wr_value)
  );

  // spread the result word onto its ports
  assign out_ok          = resp.ok;
  assign out_found_key   = resp.key;
  assign out_found_value = resp.value;
  assign out_entry_count = resp.count;
  assign out_is_empty    = resp.empty;

endmodule

FILE: hw/rtl/bkvm_checker.sv
// ---------------------------------------------------------------------------
// bkvm_checker
// Port-level checks of the map's request and result timing.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bkvm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [bkvm_pkg::OP_W-1:0]     in_operation,
  input logic                          out_valid,
  input logic                          out_ok,
  input logic [bkvm_pkg::KEY_IO_W-1:0] out_found_key,
  input logic [bkvm_pkg::VAL_IO_W-1:0] out_found_value
);

  import bkvm_pkg::*;

  // key requests always enter the scan
  `CHK_NEXT(a_key_req_busy, clk, rst_n, start && !busy && in_operation != OP_NONE && in_operation != OP_GET_BY_INDEX, busy, "key request did not raise busy")

  // a result word is shown only once the block is free again
  `CHK_IMPLY(a_word_when_idle, clk, rst_n, out_valid, !busy, "result strobe while busy")

  // leaving busy always delivers a word
  `CHK_IMPLY(a_fall_gives_word, clk, rst_n, $fell(busy), out_valid, "busy fell without a result")

  // failed requests read nothing
  `CHK_IMPLY(a_fail_zero, clk, rst_n, out_valid && !out_ok, out_found_key == '0 && out_found_value == '0, "failed request returned data")

  // no word without a request in flight
  `CHK_IMPLY(a_word_has_cause, clk, rst_n, out_valid, $past(busy) || $past(start), "result with no request")

endmodule

bind bounded_key_value_map bkvm_checker u_bkvm_checker (.*);
